/* sv/pptq_pkg.sv */
// Shared types, codes and control structs for the preemptive priority task queue.
`timescale 1ns / 1ps

package pptq_pkg;

    // Request codes carried in req_type
    typedef enum logic [1:0] {
        REQ_ADD      = 2'd0,
        REQ_DISPATCH = 2'd1,
        REQ_FINISH   = 2'd2
    } req_code_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_ADDED         = 3'd0,
        ST_FULL          = 3'd1,
        ST_DISPATCHED    = 3'd2,
        ST_NONE_RUNNABLE = 3'd3,
        ST_FINISHED      = 3'd4,
        ST_NONE_RUNNING  = 3'd5,
        ST_OVERFLOW      = 3'd6
    } status_t;

    // One request transfer
    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] task_handle;
        logic [63:0] task_argument;
        logic [7:0]  task_priority;
    } req_item_t;

    // One result transfer
    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] out_handle;
        logic [63:0] out_argument;
        logic [7:0]  out_priority;
    } rsp_item_t;

    // Controller states
    typedef enum logic [2:0] {
        CS_IDLE,
        CS_ADD_SCAN,
        CS_DISP_SCAN,
        CS_DISP_LAST,
        CS_DISP_DECIDE,
        CS_DISP_FETCH,
        CS_POP,
        CS_POP_LOAD
    } ctl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    capture;      // latch request, restart scan
        logic    scan_inc;     // advance scan index
        logic    disp_scan;    // priority read feeds the compare stage
        logic    add_write;    // store task at scan index
        logic    disp_commit;  // push level, take best task
        logic    pop_read;     // read top of level stack, drop depth
        logic    pop_commit;   // restore running level
        logic    respond;      // load result register
        status_t resp_status;
        logic    resp_data;    // result carries the fetched task
    } ctl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic slot_free;
        logic scan_last;
        logic run_ok;
        logic stack_full;
        logic stack_empty;
    } dp_stat_t;

endpackage

/* sv/pptq_ctrl.sv */
// Controller state machine of the preemptive priority task queue.
`timescale 1ns / 1ps

module pptq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        req_type,
    input  pptq_pkg::dp_stat_t stat,
    output logic              busy,
    output pptq_pkg::ctl_cmd_t cmd
);
    import pptq_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (start)
                begin
                    unique case (req_type)
                        REQ_ADD:      state_next = CS_ADD_SCAN;
                        REQ_DISPATCH: state_next = CS_DISP_SCAN;
                        REQ_FINISH:   state_next = CS_POP;
                        default:      state_next = CS_IDLE;
                    endcase
                end
            end
            CS_ADD_SCAN:
            begin
                if (stat.slot_free || stat.scan_last)
                begin
                    state_next = CS_IDLE;
                end
            end
            CS_DISP_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = CS_DISP_LAST;
                end
            end
            CS_DISP_LAST:   state_next = CS_DISP_DECIDE;
            CS_DISP_DECIDE:
            begin
                if (stat.run_ok && !stat.stack_full)
                begin
                    state_next = CS_DISP_FETCH;
                end
                else
                begin
                    state_next = CS_IDLE;
                end
            end
            CS_DISP_FETCH:  state_next = CS_IDLE;
            CS_POP:
            begin
                if (stat.stack_empty)
                begin
                    state_next = CS_IDLE;
                end
                else
                begin
                    state_next = CS_POP_LOAD;
                end
            end
            CS_POP_LOAD:    state_next = CS_IDLE;
            default:        state_next = CS_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd             = '0;
        cmd.resp_status = ST_NONE_RUNNABLE;
        busy            = (state_reg != CS_IDLE);
        unique case (state_reg)
            CS_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    // Unknown request answers at once
                    if (req_type != REQ_ADD && req_type != REQ_DISPATCH
                        && req_type != REQ_FINISH)
                    begin
                        cmd.respond     = 1'b1;
                        cmd.resp_status = ST_NONE_RUNNABLE;
                    end
                end
            end
            CS_ADD_SCAN:
            begin
                priority if (stat.slot_free)
                begin
                    cmd.add_write   = 1'b1;
                    cmd.respond     = 1'b1;
                    cmd.resp_status = ST_ADDED;
                end
                else if (stat.scan_last)
                begin
                    cmd.respond     = 1'b1;
                    cmd.resp_status = ST_FULL;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                end
            end
            CS_DISP_SCAN:
            begin
                cmd.disp_scan = 1'b1;
                cmd.scan_inc  = !stat.scan_last;
            end
            CS_DISP_LAST:
            begin
                // Let the last compare finish, no command
            end
            CS_DISP_DECIDE:
            begin
                priority if (!stat.run_ok)
                begin
                    cmd.respond     = 1'b1;
                    cmd.resp_status = ST_NONE_RUNNABLE;
                end
                else if (stat.stack_full)
                begin
                    cmd.respond     = 1'b1;
                    cmd.resp_status = ST_OVERFLOW;
                end
                else
                begin
                    cmd.disp_commit = 1'b1;
                end
            end
            CS_DISP_FETCH:
            begin
                cmd.respond     = 1'b1;
                cmd.resp_status = ST_DISPATCHED;
                cmd.resp_data   = 1'b1;
            end
            CS_POP:
            begin
                if (stat.stack_empty)
                begin
                    cmd.respond     = 1'b1;
                    cmd.resp_status = ST_NONE_RUNNING;
                end
                else
                begin
                    cmd.pop_read = 1'b1;
                end
            end
            CS_POP_LOAD:
            begin
                cmd.pop_commit  = 1'b1;
                cmd.respond     = 1'b1;
                cmd.resp_status = ST_FINISHED;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* sv/pptq_datapath.sv */
// Datapath: slot table, scan and compare, level stack and result register.
`timescale 1ns / 1ps

module pptq_datapath #(
    parameter int QUEUE_SLOTS   = 64,
    parameter int PRIORITY_BITS = 8,
    parameter int NEST_DEPTH    = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pptq_pkg::req_item_t req,
    input  pptq_pkg::ctl_cmd_t  cmd,
    output pptq_pkg::dp_stat_t  stat,
    output logic                done,
    output pptq_pkg::rsp_item_t rsp
);
    import pptq_pkg::*;

    localparam int SLOT_W  = $clog2(QUEUE_SLOTS);
    localparam int DEPTH_W = $clog2(NEST_DEPTH + 1);
    localparam int STK_AW  = $clog2(NEST_DEPTH);
    localparam int PW      = PRIORITY_BITS;

    // Slot table storage
    logic [63:0]   handle_mem [QUEUE_SLOTS];
    logic [63:0]   arg_mem    [QUEUE_SLOTS];
    logic [PW-1:0] prio_mem   [QUEUE_SLOTS];
    logic [QUEUE_SLOTS-1:0] valid_reg;

    // Level stack storage, entry is {running, level}
    logic [PW:0]   stack_mem  [NEST_DEPTH];

    // Latched request
    logic [63:0]   handle_reg;
    logic [63:0]   arg_reg;
    logic [PW-1:0] prio_reg;
    logic [PW+7:0] prio_in_ext;

    // Scan and compare
    logic [SLOT_W-1:0] scan_idx_reg;
    logic [SLOT_W-1:0] cmp_idx_reg;
    logic              cmp_en_reg;
    logic [PW-1:0]     prio_rd_reg;
    logic              best_found_reg;
    logic [SLOT_W-1:0] best_idx_reg;
    logic [PW-1:0]     best_prio_reg;
    logic              take_best;

    // Task fetch
    logic [63:0] hd_rd_reg;
    logic [63:0] arg_rd_reg;

    // Running level and stack pointer
    logic              run_valid_reg;
    logic [PW-1:0]     run_prio_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_dec;
    logic [STK_AW-1:0] stk_waddr;
    logic [STK_AW-1:0] stk_raddr;
    logic [PW:0]       stk_rd_reg;

    // Result
    rsp_item_t     rsp_reg;
    logic          done_reg;
    logic [PW+7:0] best_prio_ext;

    assign prio_in_ext   = {{PW{1'b0}}, req.task_priority};
    assign best_prio_ext = {8'd0, best_prio_reg};
    assign depth_dec     = depth_reg - DEPTH_W'(1);
    assign stk_waddr     = depth_reg[STK_AW-1:0];
    assign stk_raddr     = depth_dec[STK_AW-1:0];

    assign take_best = cmp_en_reg && valid_reg[cmp_idx_reg]
                       && (!best_found_reg || prio_rd_reg > best_prio_reg);

    // Status toward the controller
    assign stat.slot_free   = !valid_reg[scan_idx_reg];
    assign stat.scan_last   = (scan_idx_reg == SLOT_W'(QUEUE_SLOTS - 1));
    assign stat.run_ok      = best_found_reg
                              && (!run_valid_reg || best_prio_reg > run_prio_reg);
    assign stat.stack_full  = (depth_reg == DEPTH_W'(NEST_DEPTH));
    assign stat.stack_empty = (depth_reg == '0);

    // Hold the request payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            handle_reg <= req.task_handle;
            arg_reg    <= req.task_argument;
            prio_reg   <= prio_in_ext[PW-1:0];
        end
    end

    // Slot table write and registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.add_write)
        begin
            handle_mem[scan_idx_reg] <= handle_reg;
            arg_mem[scan_idx_reg]    <= arg_reg;
            prio_mem[scan_idx_reg]   <= prio_reg;
        end
        prio_rd_reg <= prio_mem[scan_idx_reg];
        hd_rd_reg   <= handle_mem[best_idx_reg];
        arg_rd_reg  <= arg_mem[best_idx_reg];
    end

    // Level stack write on push, registered read on pop
    always_ff @(posedge clk)
    begin
        if (cmd.disp_commit)
        begin
            stack_mem[stk_waddr] <= {run_valid_reg, run_prio_reg};
        end
        if (cmd.pop_read)
        begin
            stk_rd_reg <= stack_mem[stk_raddr];
        end
    end

    // Hold the priority of the best candidate seen so far
    always_ff @(posedge clk)
    begin
        if (take_best)
        begin
            best_prio_reg <= prio_rd_reg;
        end
    end

    // Control state: valid bits, scan, best, running level, depth, strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            scan_idx_reg   <= '0;
            cmp_idx_reg    <= '0;
            cmp_en_reg     <= 1'b0;
            best_found_reg <= 1'b0;
            best_idx_reg   <= '0;
            run_valid_reg  <= 1'b0;
            run_prio_reg   <= '0;
            depth_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            // Advance the scan
            if (cmd.capture)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan_inc)
            begin
                scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
            end
            cmp_en_reg  <= cmd.disp_scan;
            cmp_idx_reg <= scan_idx_reg;

            // Track the best candidate
            if (cmd.capture)
            begin
                best_found_reg <= 1'b0;
            end
            else if (take_best)
            begin
                best_found_reg <= 1'b1;
                best_idx_reg   <= cmp_idx_reg;
            end

            // Claim or free slots
            if (cmd.add_write)
            begin
                valid_reg[scan_idx_reg] <= 1'b1;
            end
            if (cmd.disp_commit)
            begin
                valid_reg[best_idx_reg] <= 1'b0;
            end

            // Push or pop the running level
            if (cmd.disp_commit)
            begin
                depth_reg     <= depth_reg + DEPTH_W'(1);
                run_valid_reg <= 1'b1;
                run_prio_reg  <= best_prio_reg;
            end
            else if (cmd.pop_read)
            begin
                depth_reg <= depth_dec;
            end
            if (cmd.pop_commit)
            begin
                run_valid_reg <= stk_rd_reg[PW];
                run_prio_reg  <= stk_rd_reg[PW-1:0];
            end

            done_reg <= cmd.respond;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            rsp_reg.status <= cmd.resp_status;
            if (cmd.resp_data)
            begin
                rsp_reg.out_handle   <= hd_rd_reg;
                rsp_reg.out_argument <= arg_rd_reg;
                rsp_reg.out_priority <= best_prio_ext[7:0];
            end
            else
            begin
                rsp_reg.out_handle   <= '0;
                rsp_reg.out_argument <= '0;
                rsp_reg.out_priority <= '0;
            end
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

/* sv/preemptive_priority_task_queue.sv */
// Top level of the preemptive priority task queue: controller plus datapath.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; its single result
// appears on rsp, marked by done for exactly one cycle, and cannot be held
// off by the receiver. Slot search walks the table one slot per cycle; a
// dispatch compares through a registered priority read. An add stops at the
// lowest free slot, a dispatch scans every slot and then fetches the chosen
// task when it dispatches one, a finish reads the level stack unless nothing
// is running, and an unknown request never makes busy high. The result shows
// in the cycle after the last busy cycle (for an unknown request, the cycle
// right after it is taken), and busy is already low then, so the next
// request may be started while a result is on the ports.
module preemptive_priority_task_queue #(
    parameter int QUEUE_SLOTS   = 64,
    parameter int PRIORITY_BITS = 8,
    parameter int NEST_DEPTH    = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  pptq_pkg::req_item_t req,
    output logic                done,
    output pptq_pkg::rsp_item_t rsp
);
    import pptq_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    // Sequence each request
    pptq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req.req_type),
        .stat     (stat),
        .busy     (busy),
        .cmd      (cmd)
    );

    // Hold slots, levels and the result
    pptq_datapath #(
        .QUEUE_SLOTS   (QUEUE_SLOTS),
        .PRIORITY_BITS (PRIORITY_BITS),
        .NEST_DEPTH    (NEST_DEPTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .done  (done),
        .rsp   (rsp)
    );

endmodule
